/* design/smau_pkg.sv */
// ----------------------------------------------------------------------------
// Miscellaneous ALU package
// Shared types, opcodes and constants of the miscellaneous-group ALU pipeline.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned DividendW       = 2 * ByteW;
  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned DivStages       = DividendW / DivBitsPerStage;
  // One front stage, the divider stages and one finishing stage.
  localparam int unsigned NumStages       = DivStages + 2;

  localparam logic [3:0]       NibbleMax = 4'd9;
  localparam logic [ByteW:0]   AdjLo     = 9'h006;
  localparam logic [ByteW:0]   AdjHi     = 9'h060;

  typedef enum logic [3:0] {
    OpNop    = 4'd0,
    OpXcn    = 4'd1,
    OpDaa    = 4'd2,
    OpDas    = 4'd3,
    OpSetBit = 4'd4,
    OpClrBit = 4'd5,
    OpTset   = 4'd6,
    OpTclr   = 4'd7,
    OpMul    = 4'd8,
    OpDiv    = 4'd9
  } op_e;

  // One item as it travels down the pipeline.
  typedef struct packed {
    op_e                   op;
    logic [ByteW-1:0]      acc;
    logic [ByteW-1:0]      y;
    logic [ByteW-1:0]      mem;
    logic                  mw;
    logic                  n;
    logic                  z;
    logic                  c;
    logic                  nzu;
    logic                  cu;
    logic [ByteW-1:0]      x;
    logic [ByteW-1:0]      rem;
    logic [DividendW-1:0]  dq;
  } item_t;

endpackage

/* design/smau_front.sv */
// ----------------------------------------------------------------------------
// Miscellaneous ALU front stage
// Decodes the opcode, executes the byte operations and the multiply,
// and seeds the divider state.
// ----------------------------------------------------------------------------
module smau_front (
  input  logic [3:0]           opcode_i,
  input  logic [7:0]           acc_in_i,
  input  logic [7:0]           x_in_i,
  input  logic [7:0]           y_in_i,
  input  logic [7:0]           mem_in_i,
  input  logic [2:0]           bit_index_i,
  output smau_pkg::item_t      item_o
);
  import smau_pkg::*;

  op_e               op;
  logic [ByteW:0]    adj;
  logic [ByteW-1:0]  bit_mask;
  logic [ByteW-1:0]  new_mem;
  logic [DividendW-1:0] prod;

  assign op       = op_e'(opcode_i);
  assign bit_mask = ByteW'(1) << bit_index_i;
  assign prod     = DividendW'(y_in_i) * DividendW'(acc_in_i);

  always_comb begin
    adj     = {1'b0, acc_in_i};
    new_mem = mem_in_i;

    item_o     = '0;
    item_o.op  = op;
    item_o.acc = acc_in_i;
    item_o.y   = y_in_i;
    item_o.mem = mem_in_i;
    item_o.x   = x_in_i;
    item_o.rem = '0;
    item_o.dq  = {y_in_i, acc_in_i};

    unique case (op)
      OpXcn: begin
        item_o.acc = {acc_in_i[3:0], acc_in_i[7:4]};
        item_o.n   = acc_in_i[3];
        item_o.z   = (acc_in_i == '0);
        item_o.nzu = 1'b1;
      end
      OpDaa: begin
        if (adj[3:0] > NibbleMax) adj = adj + AdjLo;
        if (adj[7:4] > NibbleMax) adj = adj + AdjHi;
        item_o.acc = adj[ByteW-1:0];
        item_o.c   = adj[ByteW];
        item_o.n   = adj[ByteW-1];
        item_o.z   = (adj[ByteW-1:0] == '0);
        item_o.nzu = 1'b1;
        item_o.cu  = 1'b1;
      end
      OpDas: begin
        // The adjust only subtracts from values large enough, so no borrow
        // can occur; the borrow bit is still taken from the arithmetic.
        if (adj[3:0] > NibbleMax) adj = adj - AdjLo;
        if (adj[7:4] > NibbleMax) adj = adj - AdjHi;
        item_o.acc = adj[ByteW-1:0];
        item_o.c   = adj[ByteW];
        item_o.n   = adj[ByteW-1];
        item_o.z   = (adj[ByteW-1:0] == '0);
        item_o.nzu = 1'b1;
        item_o.cu  = 1'b1;
      end
      OpSetBit: begin
        item_o.mem = mem_in_i | bit_mask;
        item_o.mw  = 1'b1;
      end
      OpClrBit: begin
        item_o.mem = mem_in_i & ~bit_mask;
        item_o.mw  = 1'b1;
      end
      OpTset, OpTclr: begin
        new_mem    = (op == OpTset) ? (mem_in_i | acc_in_i) : (mem_in_i & ~acc_in_i);
        item_o.mem = new_mem;
        item_o.mw  = 1'b1;
        item_o.n   = new_mem[ByteW-1];
        item_o.z   = (new_mem == '0);
        item_o.nzu = 1'b1;
      end
      OpMul: begin
        // Flags are formed in the finishing stage from the registered product.
        item_o.acc = prod[ByteW-1:0];
        item_o.y   = prod[DividendW-1:ByteW];
        item_o.nzu = 1'b1;
      end
      OpDiv: begin
        item_o.nzu = 1'b1;
      end
      default: begin
        item_o.op = OpNop;
      end
    endcase
  end

endmodule

/* design/smau_div_stage.sv */
// ----------------------------------------------------------------------------
// Miscellaneous ALU divider stage
// Performs a slice of restoring division steps on the remainder and the
// shifting dividend/quotient word.
// ----------------------------------------------------------------------------
module smau_div_stage (
  input  smau_pkg::item_t item_i,
  output smau_pkg::item_t item_o
);
  import smau_pkg::*;

  logic [ByteW-1:0]     rem;
  logic [DividendW-1:0] dq;
  logic [ByteW:0]       trial;
  logic                 ge;

  always_comb begin
    rem   = item_i.rem;
    dq    = item_i.dq;
    trial = '0;
    ge    = 1'b0;
    // Each step shifts in the next dividend bit and the new quotient bit.
    for (int s = 0; s < DivBitsPerStage; s++) begin
      trial = {rem, dq[DividendW-1]};
      ge    = (trial >= {1'b0, item_i.x});
      dq    = {dq[DividendW-2:0], ge};
      rem   = ge ? ByteW'(trial - {1'b0, item_i.x}) : trial[ByteW-1:0];
    end
    item_o     = item_i;
    item_o.rem = rem;
    item_o.dq  = dq;
  end

endmodule

/* design/smau_finish.sv */
// ----------------------------------------------------------------------------
// Miscellaneous ALU finishing stage
// Selects the divide result and forms the flags of multiply and divide.
// ----------------------------------------------------------------------------
module smau_finish (
  input  smau_pkg::item_t item_i,
  output smau_pkg::item_t item_o
);
  import smau_pkg::*;

  logic [ByteW-1:0] acc;
  logic [ByteW-1:0] y;

  always_comb begin
    acc = item_i.acc;
    y   = item_i.y;
    if (item_i.op == OpDiv) begin
      // A zero divisor yields zero; a wide quotient keeps its low byte.
      if (item_i.x == '0) begin
        acc = '0;
        y   = '0;
      end else begin
        acc = item_i.dq[ByteW-1:0];
        y   = item_i.rem;
      end
    end
    item_o     = item_i;
    item_o.acc = acc;
    item_o.y   = y;
    if (item_i.op == OpDiv || item_i.op == OpMul) begin
      item_o.n = y[ByteW-1];
      item_o.z = ({y, acc} == '0);
    end
  end

endmodule

/* design/spc700_misc_alu_unit.sv */
// ----------------------------------------------------------------------------
// Miscellaneous-group ALU unit
// Executes nibble swap, decimal adjusts, bit set/clear, test-and-set/clear,
// multiply and divide: six stages, one instruction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one instruction per transfer: opcode, A, X, Y,
//   the memory byte and a bit index. A transfer happens at a rising clock edge
//   where in_valid_i is high and in_stall_o is low. The output channel carries
//   the new A and Y, the byte to write back with its strobe, and the N/Z/C
//   flag values with their update strobes, transferred when out_valid_o is
//   high and out_stall_i is low.
//   Throughput is one instruction per cycle while out_stall_i is low; every
//   opcode takes the same path. The depth is set by the 16/8 divider, which
//   retires four quotient bits in each of four stages; a front stage (decode,
//   byte operations, 8x8 multiply) precedes them and a finishing stage
//   (divide result select, flags) follows.
//   Each stage holds its own valid bit, so empty stages fill even while the
//   receiver stalls; in_stall_o rises only when all six stages are occupied
//   and the output is stalled. Nothing is dropped or repeated under stall.
//   Reset clears all valid bits; the data registers are not reset. Unused
//   opcodes pass the registers and memory byte through with no updates.
// ----------------------------------------------------------------------------
module spc700_misc_alu_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [7:0] acc_in_i,
  input  logic [7:0] x_in_i,
  input  logic [7:0] y_in_i,
  input  logic [7:0] mem_in_i,
  input  logic [2:0] bit_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] acc_out_o,
  output logic [7:0] y_out_o,
  output logic [7:0] mem_out_o,
  output logic       mem_we_o,
  output logic       neg_flag_o,
  output logic       zero_flag_o,
  output logic       carry_flag_o,
  output logic       nz_update_o,
  output logic       carry_update_o
);
  import smau_pkg::*;

  // Stage registers and the combinational next values feeding each of them.
  logic  [NumStages-1:0] valid_q;
  item_t                 data_q [NumStages];
  item_t                 data_d [NumStages];
  logic  [NumStages-1:0] valid_d;
  // A stage can take a new item when it is empty or its item moves on.
  logic  [NumStages:0]   ready;

  assign ready[NumStages] = !out_stall_i;
  assign valid_d[0]       = in_valid_i;

  for (genvar gk = 0; gk < NumStages; gk++) begin : g_ready
    assign ready[gk] = !valid_q[gk] || ready[gk+1];
    if (gk > 0) begin : g_vin
      assign valid_d[gk] = valid_q[gk-1];
    end
  end

  assign in_stall_o = !ready[0];

  // The front stage decodes and executes everything but the divide.
  smau_front u_front (
    .opcode_i    (opcode_i),
    .acc_in_i    (acc_in_i),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .mem_in_i    (mem_in_i),
    .bit_index_i (bit_index_i),
    .item_o      (data_d[0])
  );

  // The divider stages each retire a slice of the quotient bits.
  for (genvar gs = 1; gs <= DivStages; gs++) begin : g_div
    smau_div_stage u_div_stage (
      .item_i (data_q[gs-1]),
      .item_o (data_d[gs])
    );
  end

  // The last stage picks the divide result and forms multiply/divide flags.
  smau_finish u_finish (
    .item_i (data_q[NumStages-2]),
    .item_o (data_d[NumStages-1])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k] && valid_d[k]) begin
        data_q[k] <= data_d[k];
      end
    end
  end

  assign out_valid_o    = valid_q[NumStages-1];
  assign acc_out_o      = data_q[NumStages-1].acc;
  assign y_out_o        = data_q[NumStages-1].y;
  assign mem_out_o      = data_q[NumStages-1].mem;
  assign mem_we_o       = data_q[NumStages-1].mw;
  assign neg_flag_o     = data_q[NumStages-1].n;
  assign zero_flag_o    = data_q[NumStages-1].z;
  assign carry_flag_o   = data_q[NumStages-1].c;
  assign nz_update_o    = data_q[NumStages-1].nzu;
  assign carry_update_o = data_q[NumStages-1].cu;

  // The input side stalls only when every stage holds an item.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a pipeline stage is empty");

  // A stalled output stage keeps its item for the next edge.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped from the output stage");

  // Decimal adjusts never write memory, and they always update N and Z.
  a_carry_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && carry_update_o) |-> (nz_update_o && !mem_we_o))
    else $error("carry update with inconsistent strobes");

  // All flag values stay zero when the N/Z update strobe is low.
  a_flag_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !nz_update_o) |-> (!neg_flag_o && !zero_flag_o && !carry_flag_o))
    else $error("flag value set without an update strobe");

endmodule
